// ----- hw/rtl/modular_square_root_macros.svh -----
// Assertion macros used by the checker file.
`ifndef MODULAR_SQUARE_ROOT_MACROS_SVH
`define MODULAR_SQUARE_ROOT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define MSR_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define MSR_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ----- hw/rtl/msr_pkg.sv -----
// Package with widths, status codes and sequencer states for the square root block.
package msr_pkg;
  localparam int W = 32;
  localparam int CW = 5;

  typedef enum logic [1:0] {
    ST_FOUND = 2'd0,
    ST_NONE = 2'd1,
    ST_UNSUP = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  // Top-level sequencer states
  typedef enum logic [3:0] {
    S_IDLE, S_POW_SQ, S_POW_SQW, S_POW_MUL, S_POW_MULW, S_NEXT,
    S_CHK, S_CHKW, S_G2, S_G4, S_FIN, S_OUT
  } state_t;
endpackage

// ----- hw/rtl/msr_mulmod.sv -----
// Shift-and-add modular multiplier, one bit of the multiplier each cycle.
module msr_mulmod import msr_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] a_in,
  input  logic [W-1:0] b_in,
  input  logic [W-1:0] p_in,
  output logic         done,
  output logic [W-1:0] prod
);
  logic [W-1:0] a_r, a_nxt, b_r, b_nxt, acc_r, acc_nxt;
  logic busy_r, busy_nxt, done_r, done_nxt;

  // Modular add: (x + y) mod p with x, y < p, wide sum then one subtract
  function automatic logic [W-1:0] addm(input logic [W-1:0] x, input logic [W-1:0] y,
                                        input logic [W-1:0] p);
    logic [W:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, p}) addm = W'(s - {1'b0, p});
    else addm = s[W-1:0];
  endfunction

  always_comb begin
    a_nxt = a_r;
    b_nxt = b_r;
    acc_nxt = acc_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      a_nxt = a_in;
      b_nxt = b_in;
      acc_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (b_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        if (b_r[0]) acc_nxt = addm(acc_r, a_r, p_in);
        a_nxt = addm(a_r, a_r, p_in);
        b_nxt = b_r >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    a_r <= a_nxt;
    b_r <= b_nxt;
    acc_r <= acc_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign prod = acc_r;
endmodule

// ----- hw/rtl/modular_square_root.sv -----
// Top level: modular square root for p = 3 mod 4 and p = 5 mod 8.
// Latency: range, zero and unsupported cases offer the result the cycle after input transfer.
// p = 3 mod 4: one exponentiation plus a check multiply; p = 5 mod 8: two exponentiations,
// plus a final multiply by 2g when the first exponentiation yields p - 1.
// Throughput: one item at a time; in_tready is low until the result is transferred.
// Reset (rst_n, synchronous, active low) returns to idle and sets the modulus to 3.
module modular_square_root import msr_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_wen,
  input  logic [W-1:0]  cfg_wdata,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [31:0]   in_tdata,   // [31:0] g_value
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [71:0]   out_tdata   // [31:0] root, [63:32] other_root, [65:64] status
);
  state_t st_r, st_nxt;
  logic [W-1:0] p_r, g_r, g_nxt, x_r, x_nxt, base_r, base_nxt, e_r, e_nxt;
  logic [W-1:0] y_r, y_nxt, u_r, u_nxt;
  logic [CW-1:0] bit_r, bit_nxt;
  logic [1:0] phase_r, phase_nxt;   // 0 check/z pow, 1 second pow, 2 (4g)^u pow, 3 final multiply
  status_t stat_r, stat_nxt;
  logic mul_start, mul_done;
  logic [W-1:0] ma, mb, mprod;
  logic [W:0] g2s;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) p_r <= W'(3);
    else if (cfg_wen) p_r <= cfg_wdata;
  end

  msr_mulmod u_mul (
    .clk(clk), .rst_n(rst_n), .start(mul_start), .a_in(ma), .b_in(mb),
    .p_in(p_r), .done(mul_done), .prod(mprod)
  );

  assign in_tready = (st_r == S_IDLE);
  assign out_tvalid = (st_r == S_OUT);
  assign out_tdata = {6'd0, stat_r,
                      ((stat_r == ST_FOUND) && (y_r != '0)) ? p_r - y_r : W'(0), y_r};
  assign g2s = {1'b0, x_r} + {1'b0, x_r};

  // Sequencer
  always_comb begin
    st_nxt = st_r; g_nxt = g_r; x_nxt = x_r; base_nxt = base_r; e_nxt = e_r;
    y_nxt = y_r; u_nxt = u_r; bit_nxt = bit_r; phase_nxt = phase_r; stat_nxt = stat_r;
    mul_start = 1'b0; ma = x_r; mb = x_r;
    case (st_r)
      S_IDLE: begin
        if (in_tvalid) begin
          g_nxt = in_tdata; y_nxt = '0; phase_nxt = 2'd0; base_nxt = in_tdata;
          x_nxt = (p_r == W'(1)) ? '0 : W'(1); bit_nxt = CW'(W - 1);
          if (in_tdata >= p_r) begin stat_nxt = ST_RANGE; st_nxt = S_OUT; end
          else if (in_tdata == '0) begin stat_nxt = ST_FOUND; st_nxt = S_OUT; end
          else if (p_r[1:0] == 2'b11) begin
            u_nxt = p_r >> 2; e_nxt = (p_r >> 2) + W'(1); st_nxt = S_POW_SQ;
          end else if (p_r[2:0] == 3'b101) begin
            u_nxt = p_r >> 3; e_nxt = ((p_r >> 3) << 1) + W'(1); st_nxt = S_POW_SQ;
          end else begin stat_nxt = ST_UNSUP; st_nxt = S_OUT; end
        end
      end
      S_POW_SQ: begin mul_start = 1'b1; st_nxt = S_POW_SQW; end
      S_POW_SQW: if (mul_done) begin
        x_nxt = mprod;
        st_nxt = e_r[bit_r] ? S_POW_MUL : S_NEXT;
      end
      S_POW_MUL: begin mul_start = 1'b1; ma = x_r; mb = base_r; st_nxt = S_POW_MULW; end
      S_POW_MULW: if (mul_done) begin x_nxt = mprod; st_nxt = S_NEXT; end
      S_NEXT: begin
        if (bit_r != '0) begin bit_nxt = bit_r - CW'(1); st_nxt = S_POW_SQ; end
        else if (p_r[1:0] == 2'b11) st_nxt = S_CHK;
        else if (phase_r != 2'd0) st_nxt = S_FIN;
        else begin
          x_nxt = W'(1); bit_nxt = CW'(W - 1);
          if (x_r == W'(1)) begin
            phase_nxt = 2'd1; e_nxt = u_r + W'(1); st_nxt = S_POW_SQ;
          end else if (x_r == p_r - W'(1)) begin
            phase_nxt = 2'd2; x_nxt = g_r; st_nxt = S_G2;
          end else begin stat_nxt = ST_NONE; st_nxt = S_OUT; end
        end
      end
      // x holds g here; form 2g then 4g as base, keep 2g in y
      S_G2: begin
        x_nxt = (g2s >= {1'b0, p_r}) ? W'(g2s - {1'b0, p_r}) : g2s[W-1:0];
        st_nxt = S_G4;
      end
      S_G4: begin
        y_nxt = x_r;
        base_nxt = (g2s >= {1'b0, p_r}) ? W'(g2s - {1'b0, p_r}) : g2s[W-1:0];
        x_nxt = W'(1); e_nxt = u_r; bit_nxt = CW'(W - 1); st_nxt = S_POW_SQ;
      end
      S_CHK: begin mul_start = 1'b1; st_nxt = S_CHKW; end
      S_CHKW: if (mul_done) begin
        if (mprod == g_r) begin y_nxt = x_r; stat_nxt = ST_FOUND; end
        else stat_nxt = ST_NONE;
        st_nxt = S_OUT;
      end
      S_FIN: begin
        if (phase_r == 2'd1) begin y_nxt = x_r; stat_nxt = ST_FOUND; st_nxt = S_OUT; end
        else begin mul_start = 1'b1; ma = y_r; mb = x_r; phase_nxt = 2'd3; end
        if (phase_r == 2'd3 && mul_done) begin
          y_nxt = mprod; stat_nxt = ST_FOUND; st_nxt = S_OUT;
        end else if (phase_r == 2'd3) mul_start = 1'b0;
      end
      S_OUT: if (out_tready) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    g_r <= g_nxt; x_r <= x_nxt; base_r <= base_nxt; e_r <= e_nxt;
    y_r <= y_nxt; u_r <= u_nxt; bit_r <= bit_nxt; phase_r <= phase_nxt;
    stat_r <= stat_nxt;
    if (!rst_n) st_r <= S_IDLE;
    else st_r <= st_nxt;
  end
endmodule

// ----- hw/rtl/msr_checker.sv -----
// Port-level checker for the square root block, bound to the top level.
`include "modular_square_root_macros.svh"
module msr_checker import msr_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [71:0] out_tdata
);
  // One item in flight: never ready while a result waits
  `MSR_ASSERT_IMP(a_excl, out_tvalid, !in_tready)
  // Result held while stalled
  `MSR_ASSERT_NXT(a_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  // Non-found status carries zero roots
  `MSR_ASSERT_IMP(a_zero, out_tvalid && out_tdata[65:64] != ST_FOUND, out_tdata[63:0] == 64'd0)
  // Accepted input makes the block busy
  `MSR_ASSERT_NXT(a_busy, in_tvalid && in_tready, !in_tready)
endmodule

bind modular_square_root msr_checker u_msr_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);

// ----- tb/tb.sv -----
// Self-checking testbench for the modular square root block.
module tb;
  import msr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOLD_CYCLES = 6000;
  localparam int STALL_LIMIT = 40000;

  typedef struct {
    logic [31:0] root;
    logic [31:0] other_root;
    status_t     status;
  } root_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wen = 1'b0;
  logic [W-1:0] cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;

  logic [31:0]    g_pending[$];
  root_result_t   roots_due[$];
  logic [W-1:0]   cur_modulus = W'(3);
  int             send_idle_pct = 0;
  int             recv_stall_pct = 0;
  bit             hold_request = 1'b0;
  bit             in_took = 1'b0;
  int             hold_left = 0;
  int             quiet_cycles = 0;
  int             errors = 0;

  modular_square_root dut (.*);

  always #5 clk = ~clk;

  // base^e mod p by square-and-multiply; operands below p fit a 64-bit product
  function automatic longint unsigned pow_mod(longint unsigned base, longint unsigned e,
                                              longint unsigned p);
    longint unsigned x;
    x = 1 % p;
    for (int b = 63; b >= 0; b--) begin
      x = (x * x) % p;
      if (e[b]) x = (x * base) % p;
    end
    return x;
  endfunction

  function automatic root_result_t predict_root(logic [31:0] g_in, logic [W-1:0] p_in);
    root_result_t r;
    longint unsigned p, g, u, y, z, g2, g4;
    p = p_in;
    g = g_in;
    y = 0;
    r.other_root = '0;
    if (g >= p) r.status = ST_RANGE;
    else if (g == 0) r.status = ST_FOUND;
    else if (p[1:0] == 2'b11) begin
      u = p >> 2;
      y = pow_mod(g, u + 1, p);
      if ((y * y) % p == g) r.status = ST_FOUND;
      else begin
        r.status = ST_NONE;
        y = 0;
      end
    end else if (p[2:0] == 3'b101) begin
      u = p >> 3;
      z = pow_mod(g, 2 * u + 1, p);
      if (z == 1) begin
        y = pow_mod(g, u + 1, p);
        r.status = ST_FOUND;
      end else if (z == p - 1) begin
        g2 = (2 * g) % p;
        g4 = (2 * g2) % p;
        y = (g2 * pow_mod(g4, u, p)) % p;
        r.status = ST_FOUND;
      end else r.status = ST_NONE;
    end else r.status = ST_UNSUP;
    if (r.status == ST_FOUND && y != 0) r.other_root = 32'(p - y);
    r.root = 32'(y);
    return r;
  endfunction

  // Input side: sample transfers, predict the result
  always @(posedge clk) begin
    in_took <= in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) begin
      roots_due.push_back(predict_root(g_pending[0], cur_modulus));
      void'(g_pending.pop_front());
    end
  end

  // Driver: present the head of the pending queue
  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || in_took)) begin
      if (g_pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_tvalid <= 1'b1;
        in_tdata  <= g_pending[0];
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver backpressure, with one long hold on request
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (hold_request) begin
      hold_request <= 1'b0;
      hold_left    <= HOLD_CYCLES;
      out_tready   <= 1'b0;
    end else begin
      out_tready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: compare each result transfer with the oldest prediction
  always @(posedge clk) begin
    root_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (roots_due.size() == 0) begin
        errors++;
        $display("%0t unexpected result: expected none, actual %h", $time, out_tdata);
      end else begin
        want = roots_due.pop_front();
        if (out_tdata[31:0] !== want.root) begin
          errors++;
          $display("%0t root: expected %h, actual %h", $time, want.root, out_tdata[31:0]);
        end
        if (out_tdata[63:32] !== want.other_root) begin
          errors++;
          $display("%0t other_root: expected %h, actual %h", $time, want.other_root,
                   out_tdata[63:32]);
        end
        if (out_tdata[65:64] !== want.status) begin
          errors++;
          $display("%0t status: expected %0d, actual %0d", $time, want.status,
                   out_tdata[65:64]);
        end
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic drain();
    wait (g_pending.size() == 0 && roots_due.size() == 0);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_modulus(logic [W-1:0] p);
    drain();
    @(negedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= p;
    @(negedge clk);
    cfg_wen     <= 1'b0;
    cur_modulus <= p;
  endtask

  // Mostly squares mod p (real roots), some arbitrary values and edges
  task automatic queue_random(int n);
    longint unsigned p, r;
    int pick;
    p = cur_modulus;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      r = $urandom_range(32'(p - 1), 0);
      if (pick < 55) g_pending.push_back(32'((r * r) % p));
      else if (pick < 80) g_pending.push_back($urandom);
      else if (pick < 88) g_pending.push_back(32'(r));
      else if (pick < 93) g_pending.push_back(32'(p - 1));
      else if (pick < 97) g_pending.push_back(32'(p));
      else g_pending.push_back($urandom_range(1) ? 32'hFFFF_FFFF : 32'h0);
    end
  endtask

  initial begin
    logic [W-1:0] rnd_p;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: extremes, both formulas, unsupported moduli
    set_modulus(W'(3));
    g_pending = '{32'd0, 32'd1, 32'd2, 32'd3, 32'hFFFF_FFFF};
    set_modulus(W'(7));
    g_pending = '{32'd1, 32'd2, 32'd3, 32'd4};
    set_modulus(W'(13));
    g_pending = '{32'd1, 32'd3, 32'd4, 32'd5, 32'd10, 32'd12};
    set_modulus(W'(17));
    g_pending = '{32'd0, 32'd5};
    set_modulus(W'(32'hFFFF_FFFE));
    g_pending = '{32'd1};
    set_modulus(W'(32'hFFFF_FFFF));
    g_pending = '{32'hFFFF_FFFE, 32'h0};

    // Random: no idling, with a long receiver hold
    set_modulus(W'(32'd4294967291));
    hold_request = 1'b1;
    queue_random(30);
    // Sender mostly idle
    set_modulus(W'(32'hFFFF_FFFD));
    send_idle_pct = 82;
    recv_stall_pct = 0;
    queue_random(30);
    // Receiver mostly stalling
    set_modulus(W'(32'd1000003));
    send_idle_pct = 0;
    recv_stall_pct = 82;
    queue_random(30);
    // Both idling, random modulus of either supported class or not
    rnd_p = W'({$urandom_range(32'h7FFF_FFFF, 2), 1'b1});
    set_modulus(rnd_p);
    send_idle_pct = 21;
    recv_stall_pct = 21;
    queue_random(20);
    set_modulus(W'(32'd29));
    queue_random(15);

    drain();
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end
endmodule
